/* rtl/core/flat_face_lighting_unit_macros.svh */
// Assertion macros used by the flat face lighting unit.
`ifndef FLAT_FACE_LIGHTING_UNIT_MACROS_SVH
`define FLAT_FACE_LIGHTING_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define FFL_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("flat_face_lighting_unit: assertion failed");
`define FFL_ASSERT_NORST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("flat_face_lighting_unit: reset assertion failed");
`else
`define FFL_ASSERT(name, prop)
`define FFL_ASSERT_NORST(name, prop)
`endif

`endif

/* rtl/core/ffl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ffl_pkg;

  localparam int Axes     = 3;
  localparam int CoordW   = 16;
  localparam int EdgeW    = 17;
  localparam int ProdW    = 34;
  localparam int NormW    = 35;
  localparam int MagW     = 34;
  localparam int NrmW     = 30;
  localparam int SgnNrmW  = 31;
  localparam int SqrW     = 60;
  localparam int SqW      = 62;
  localparam int RootW    = 31;
  localparam int RemW     = 34;
  localparam int DirW     = 16;
  localparam int DotProdW = 47;
  localparam int DotW     = 48;
  localparam int QuotW    = 19;
  localparam int DivRemW  = 32;
  localparam int AmagW    = 15;
  localparam int IntenW   = 16;
  localparam int CProdW   = 31;
  localparam int ColorW   = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // The largest normalized magnitude has its leading one at this bit.
  localparam logic [5:0] NormTop = 6'd29;
  localparam logic [AmagW-1:0] AlignOne = 15'd16384;
  localparam logic [31:0] RoundHalf = 32'd8192;
  localparam logic signed [DirW-1:0] DirZReset = 16'sd16384;

  localparam logic [CfgIdxW-1:0] CfgLightKind = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIntenRed  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIntenGrn  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIntenBlu  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDirX      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDirY      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDirZ      = 3'd6;

  typedef struct packed {
    logic            valid;
    logic            degen;
    logic            neg;
    logic [DotW-1:0] dmag;
  } ffl_sqrt_side_t;

  typedef struct packed {
    logic valid;
    logic degen;
    logic neg;
  } ffl_div_side_t;

  function automatic logic [4:0] msb17(input logic [16:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ffl_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ffl_in_if import ffl_pkg::*;;
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] v0_x;
  logic signed [CoordW-1:0] v0_y;
  logic signed [CoordW-1:0] v0_z;
  logic signed [CoordW-1:0] v1_x;
  logic signed [CoordW-1:0] v1_y;
  logic signed [CoordW-1:0] v1_z;
  logic signed [CoordW-1:0] v2_x;
  logic signed [CoordW-1:0] v2_y;
  logic signed [CoordW-1:0] v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/ffl_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ffl_out_if import ffl_pkg::*;;
  logic valid;
  logic ready;
  logic signed [ColorW-1:0] lit_red;
  logic signed [ColorW-1:0] lit_green;
  logic signed [ColorW-1:0] lit_blue;
  logic degenerate;

  modport source (output valid, lit_red, lit_green, lit_blue, degenerate, input ready);
  modport sink (input valid, lit_red, lit_green, lit_blue, degenerate, output ready);
endinterface

`default_nettype wire

/* rtl/core/flat_face_lighting_unit.sv */
// Flat Lambertian face lighting, fully pipelined over 65 register stages.
// Throughput: one triangle per cycle while the output is not stalled; the stage
// count is set by the bit-serial square root (31) and divider (19).
// Reset is synchronous and active low; it empties the pipe and loads the
// registers with light_kind 0, zero intensities and direction (0, 0, +1.0).
`timescale 1ns / 1ps
`default_nettype none
`include "flat_face_lighting_unit_macros.svh"

module flat_face_lighting_unit import ffl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  ffl_in_if.sink              in_tri,
  ffl_out_if.source           out_lit,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic en;

  // Configuration registers.
  logic                   light_kind_r;
  logic [IntenW-1:0]      inten_r [Axes];
  logic signed [DirW-1:0] dir_r   [Axes];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_kind_r <= 1'b0;
      for (int i = 0; i < Axes; i++) inten_r[i] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DirZReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgLightKind: light_kind_r <= cfg_wdata[0];
        CfgIntenRed:  inten_r[0] <= cfg_wdata;
        CfgIntenGrn:  inten_r[1] <= cfg_wdata;
        CfgIntenBlu:  inten_r[2] <= cfg_wdata;
        CfgDirX:      dir_r[0] <= $signed(cfg_wdata);
        CfgDirY:      dir_r[1] <= $signed(cfg_wdata);
        CfgDirZ:      dir_r[2] <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // The whole pipe advances unless a finished result is waiting.
  assign en           = !out_lit.valid || out_lit.ready;
  assign in_tri.ready = en;

  // Valid bits of front stages 1..11 and degenerate flags of stages 6..11.
  logic [10:0] vld_r;
  logic [5:0]  dg_r;

  // Stage 1: edge vectors.
  logic signed [EdgeW-1:0] ea_nxt [Axes];
  logic signed [EdgeW-1:0] eb_nxt [Axes];
  logic signed [EdgeW-1:0] ea_r   [Axes];
  logic signed [EdgeW-1:0] eb_r   [Axes];

  always_comb begin
    ea_nxt[0] = $signed({in_tri.v1_x[CoordW-1], in_tri.v1_x})
              - $signed({in_tri.v0_x[CoordW-1], in_tri.v0_x});
    ea_nxt[1] = $signed({in_tri.v1_y[CoordW-1], in_tri.v1_y})
              - $signed({in_tri.v0_y[CoordW-1], in_tri.v0_y});
    ea_nxt[2] = $signed({in_tri.v1_z[CoordW-1], in_tri.v1_z})
              - $signed({in_tri.v0_z[CoordW-1], in_tri.v0_z});
    eb_nxt[0] = $signed({in_tri.v2_x[CoordW-1], in_tri.v2_x})
              - $signed({in_tri.v0_x[CoordW-1], in_tri.v0_x});
    eb_nxt[1] = $signed({in_tri.v2_y[CoordW-1], in_tri.v2_y})
              - $signed({in_tri.v0_y[CoordW-1], in_tri.v0_y});
    eb_nxt[2] = $signed({in_tri.v2_z[CoordW-1], in_tri.v2_z})
              - $signed({in_tri.v0_z[CoordW-1], in_tri.v0_z});
  end

  // Stage 2: the six cross-product terms.
  logic signed [ProdW-1:0] p_nxt [6];
  logic signed [ProdW-1:0] p_r   [6];

  always_comb begin
    p_nxt[0] = ea_r[1] * eb_r[2];
    p_nxt[1] = ea_r[2] * eb_r[1];
    p_nxt[2] = ea_r[2] * eb_r[0];
    p_nxt[3] = ea_r[0] * eb_r[2];
    p_nxt[4] = ea_r[0] * eb_r[1];
    p_nxt[5] = ea_r[1] * eb_r[0];
  end

  // Stage 3: normal components; stage 4: magnitudes and signs.
  logic signed [NormW-1:0] n_nxt [Axes];
  logic signed [NormW-1:0] n_r   [Axes];
  logic [MagW-1:0]         mag_nxt [Axes];
  logic [MagW-1:0]         mag4_r  [Axes];
  logic [MagW-1:0]         mag5_r  [Axes];
  logic [MagW-1:0]         mag6_r  [Axes];
  logic [MagW-1:0]         mag7_r  [Axes];
  logic [Axes-1:0]         sgn4_r, sgn5_r, sgn6_r, sgn7_r;

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      n_nxt[i]   = NormW'(p_r[2*i]) - NormW'(p_r[2*i+1]);
      mag_nxt[i] = MagW'(n_r[i][NormW-1] ? -n_r[i] : n_r[i]);
    end
  end

  // Stage 5: largest magnitude.
  logic [MagW-1:0] big_nxt, big_r;

  always_comb begin
    big_nxt = mag4_r[0];
    if (mag4_r[1] > big_nxt) big_nxt = mag4_r[1];
    if (mag4_r[2] > big_nxt) big_nxt = mag4_r[2];
  end

  // Stage 6: leading-one search in two halves; stage 7: shift amount.
  logic [4:0] hi_idx_r, lo_idx_r;
  logic       hi_nz_r;
  logic [5:0] pos;
  logic       rsh_nxt, rsh_r;
  logic [4:0] amt_nxt, amt_r;

  always_comb begin
    pos     = hi_nz_r ? 6'(hi_idx_r) + 6'd17 : 6'(lo_idx_r);
    rsh_nxt = pos >= NormTop;
    amt_nxt = rsh_nxt ? 5'(pos - NormTop) : 5'(NormTop - pos);
  end

  // Stage 8: normalized magnitudes and their signed forms.
  logic [MagW-1:0]            sh      [Axes];
  logic [NrmW-1:0]            m_nxt   [Axes];
  logic [NrmW-1:0]            m_r     [Axes];
  logic signed [SgnNrmW-1:0]  c_nxt   [Axes];
  logic signed [SgnNrmW-1:0]  c_r     [Axes];

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      sh[i]    = rsh_r ? mag7_r[i] >> amt_r : mag7_r[i] << amt_r;
      m_nxt[i] = sh[i][NrmW-1:0];
      c_nxt[i] = sgn7_r[i] ? -$signed({1'b0, m_nxt[i]}) : $signed({1'b0, m_nxt[i]});
    end
  end

  // Stage 9: squares and direction products; stage 10: sums; stage 11: |d|.
  // The squared length waits one more stage so that it meets |d| at the root.
  logic [SqrW-1:0]            sqr_nxt [Axes];
  logic [SqrW-1:0]            sqr_r   [Axes];
  logic signed [DotProdW-1:0] dp_nxt  [Axes];
  logic signed [DotProdW-1:0] dp_r    [Axes];
  logic [SqW-1:0]             sq_nxt, sq_r, sq11_r;
  logic signed [DotW-1:0]     d_nxt, d_r;
  logic [DotW-1:0]            dmag_r;
  logic                       neg11_r;

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      sqr_nxt[i] = m_r[i] * m_r[i];
      dp_nxt[i]  = dir_r[i] * c_r[i];
    end
    sq_nxt = SqW'(sqr_r[0]) + SqW'(sqr_r[1]) + SqW'(sqr_r[2]);
    d_nxt  = DotW'(dp_r[0]) + DotW'(dp_r[1]) + DotW'(dp_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Axes; i++) begin
        ea_r[i]   <= ea_nxt[i];
        eb_r[i]   <= eb_nxt[i];
        n_r[i]    <= n_nxt[i];
        mag4_r[i] <= mag_nxt[i];
        mag5_r[i] <= mag4_r[i];
        mag6_r[i] <= mag5_r[i];
        mag7_r[i] <= mag6_r[i];
        m_r[i]    <= m_nxt[i];
        c_r[i]    <= c_nxt[i];
        sqr_r[i]  <= sqr_nxt[i];
        dp_r[i]   <= dp_nxt[i];
        sgn4_r[i] <= n_r[i][NormW-1];
      end
      for (int j = 0; j < 6; j++) p_r[j] <= p_nxt[j];
      sgn5_r   <= sgn4_r;
      sgn6_r   <= sgn5_r;
      sgn7_r   <= sgn6_r;
      big_r    <= big_nxt;
      hi_idx_r <= msb17(big_r[MagW-1:17]);
      lo_idx_r <= msb17(big_r[16:0]);
      hi_nz_r  <= |big_r[MagW-1:17];
      rsh_r    <= rsh_nxt;
      amt_r    <= amt_nxt;
      sq_r     <= sq_nxt;
      sq11_r   <= sq_r;
      d_r      <= d_nxt;
      dmag_r   <= DotW'(d_r[DotW-1] ? -d_r : d_r);
      neg11_r  <= d_r[DotW-1];
      dg_r     <= {dg_r[4:0], big_r == '0};
    end
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[9:0], in_tri.valid};
    end
  end

  // Square root of the squared length.
  ffl_sqrt_side_t     sqrt_side_in, sqrt_side_out;
  logic [RootW-1:0]   len;

  assign sqrt_side_in = '{valid: vld_r[10], degen: dg_r[5], neg: neg11_r, dmag: dmag_r};

  ffl_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .sq_in    (sq11_r),
    .side_in  (sqrt_side_in),
    .root_out (len),
    .side_out (sqrt_side_out)
  );

  // Stage 43: rounding bias added to the numerator.
  logic [DotW-1:0]  num_r;
  logic [RootW-1:0] len_r;
  ffl_div_side_t    div_side_r, div_side_out;
  logic [QuotW-1:0] quot;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r      <= sqrt_side_out.dmag + DotW'(len >> 1);
      len_r      <= len;
    end
    if (!rst_n) begin
      div_side_r <= '0;
    end else if (en) begin
      div_side_r <= '{valid: sqrt_side_out.valid, degen: sqrt_side_out.degen,
                      neg: sqrt_side_out.neg};
    end
  end

  ffl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .num_in   (num_r),
    .den_in   (len_r),
    .side_in  (div_side_r),
    .quot_out (quot),
    .side_out (div_side_out)
  );

  // Stage 63: saturated alignment; stage 64: color products; stage 65: output.
  logic [AmagW-1:0]          amag_r;
  logic                      neg13_r, dg13_r, vld13_r;
  logic [CProdW-1:0]         cp_nxt [Axes];
  logic [CProdW-1:0]         cp_r   [Axes];
  logic                      neg14_r, dg14_r, vld14_r;
  logic [31:0]               rsum   [Axes];
  logic [ColorW-1:0]         rnd    [Axes];
  logic signed [ColorW-1:0]  lit_nxt [Axes];
  logic signed [ColorW-1:0]  lit_r   [Axes];
  logic                      dg_out_nxt, dg_out_r, out_valid_r;

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      cp_nxt[i] = inten_r[i] * amag_r;
      rsum[i]   = 32'(cp_r[i]) + RoundHalf;
      rnd[i]    = rsum[i][30:14];
      if (light_kind_r) begin
        lit_nxt[i] = $signed({1'b0, inten_r[i]});
      end else if (dg14_r) begin
        lit_nxt[i] = '0;
      end else begin
        lit_nxt[i] = neg14_r ? -$signed(rnd[i]) : $signed(rnd[i]);
      end
    end
    dg_out_nxt = !light_kind_r && dg14_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amag_r   <= (quot > QuotW'(AlignOne)) ? AlignOne : quot[AmagW-1:0];
      neg13_r  <= div_side_out.neg && (quot != '0);
      dg13_r   <= div_side_out.degen;
      for (int i = 0; i < Axes; i++) begin
        cp_r[i]  <= cp_nxt[i];
        lit_r[i] <= lit_nxt[i];
      end
      neg14_r  <= neg13_r;
      dg14_r   <= dg13_r;
      dg_out_r <= dg_out_nxt;
    end
    if (!rst_n) begin
      vld13_r     <= 1'b0;
      vld14_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld13_r     <= div_side_out.valid;
      vld14_r     <= vld13_r;
      out_valid_r <= vld14_r;
    end
  end

  assign out_lit.valid      = out_valid_r;
  assign out_lit.lit_red    = lit_r[0];
  assign out_lit.lit_green  = lit_r[1];
  assign out_lit.lit_blue   = lit_r[2];
  assign out_lit.degenerate = dg_out_r;

  logic out_dark;
  assign out_dark = lit_r[0] == '0 && lit_r[1] == '0 && lit_r[2] == '0;

  // A degenerate face carries no color.
  `FFL_ASSERT(a_degen_dark, out_lit.valid && out_lit.degenerate |-> out_dark)
  `FFL_ASSERT(a_ambient_flag, out_lit.valid && light_kind_r |-> !out_lit.degenerate)
  `FFL_ASSERT(a_stall_holds_input, out_lit.valid && !out_lit.ready |-> !in_tri.ready)
  `FFL_ASSERT_NORST(a_reset_empty, !rst_n |=> !out_lit.valid)

endmodule

`default_nettype wire

/* rtl/core/ffl_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

// Floor square root, one result bit per pipeline stage.
module ffl_isqrt import ffl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [SqW-1:0]       sq_in,
  input  ffl_sqrt_side_t       side_in,
  output logic [RootW-1:0]     root_out,
  output ffl_sqrt_side_t       side_out
);

  logic [SqW-1:0]   sq_r   [RootW];
  logic [RemW-1:0]  rem_r  [RootW];
  logic [RootW-1:0] root_r [RootW];
  ffl_sqrt_side_t   side_r [RootW];

  genvar k;
  for (k = 0; k < RootW; k++) begin : g_step
    logic [SqW-1:0]   sq_cur;
    logic [RemW-1:0]  rem_cur;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic [RootW-1:0] root_cur;
    ffl_sqrt_side_t   side_cur;
    logic             ge;

    if (k == 0) begin : g_first
      assign sq_cur   = sq_in;
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign side_cur = side_in;
    end else begin : g_next
      assign sq_cur   = sq_r[k-1];
      assign rem_cur  = rem_r[k-1];
      assign root_cur = root_r[k-1];
      assign side_cur = side_r[k-1];
    end

    // The remainder never exceeds twice the partial root, so its top two bits are free.
    assign rem_sh = {rem_cur[RemW-3:0], sq_cur[SqW-1 -: 2]};
    assign trial  = {1'b0, root_cur, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]   <= sq_cur << 2;
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_cur[RootW-2:0], ge};
      end
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_cur;
      end
    end
  end

  assign root_out = root_r[RootW-1];
  assign side_out = side_r[RootW-1];

endmodule

`default_nettype wire

/* rtl/core/ffl_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage.
module ffl_div import ffl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [DotW-1:0]    num_in,
  input  logic [RootW-1:0]   den_in,
  input  ffl_div_side_t      side_in,
  output logic [QuotW-1:0]   quot_out,
  output ffl_div_side_t      side_out
);

  logic [DivRemW-1:0] rem_r  [QuotW];
  logic [QuotW-1:0]   low_r  [QuotW];
  logic [QuotW-1:0]   quot_r [QuotW];
  logic [RootW-1:0]   den_r  [QuotW];
  ffl_div_side_t      side_r [QuotW];

  genvar k;
  for (k = 0; k < QuotW; k++) begin : g_step
    logic [DivRemW-1:0] rem_cur;
    logic [DivRemW-1:0] rem_sh;
    logic [DivRemW-1:0] den_ext;
    logic [QuotW-1:0]   low_cur;
    logic [QuotW-1:0]   quot_cur;
    logic [RootW-1:0]   den_cur;
    ffl_div_side_t      side_cur;
    logic               ge;

    if (k == 0) begin : g_first
      // The quotient fits in QuotW bits, so the upper numerator bits start below the divisor.
      assign rem_cur  = DivRemW'(num_in >> QuotW);
      assign low_cur  = num_in[QuotW-1:0];
      assign quot_cur = '0;
      assign den_cur  = den_in;
      assign side_cur = side_in;
    end else begin : g_next
      assign rem_cur  = rem_r[k-1];
      assign low_cur  = low_r[k-1];
      assign quot_cur = quot_r[k-1];
      assign den_cur  = den_r[k-1];
      assign side_cur = side_r[k-1];
    end

    assign rem_sh  = {rem_cur[DivRemW-2:0], low_cur[QuotW-1]};
    assign den_ext = {1'b0, den_cur};
    assign ge      = rem_sh >= den_ext;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_sh - den_ext : rem_sh;
        low_r[k]  <= low_cur << 1;
        quot_r[k] <= {quot_cur[QuotW-2:0], ge};
        den_r[k]  <= den_cur;
      end
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_cur;
      end
    end
  end

  assign quot_out = quot_r[QuotW-1];
  assign side_out = side_r[QuotW-1];

endmodule

`default_nettype wire
